FILE: rtl/i2cbm_pkg.sv
// Shared types, constants and phase table of the I2C master bit engine.
package i2cbm_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int TICK_W = 16;
	localparam int PHASE_W = 5;
	localparam int BIT_IDX_W = 4;
	localparam int QUEUE_DEPTH_DEF = 2;
	localparam logic [TICK_W-1:0] DELAY_RESET = 16'd200;
	localparam logic [PHASE_W-1:0] READ_BIT_PHASES = PHASE_W'(2 * BITS_PER_BYTE);

	typedef enum logic [2:0] {
		CMD_START     = 3'd0,
		CMD_STOP      = 3'd1,
		CMD_WRITE     = 3'd2,
		CMD_READ      = 3'd3,
		CMD_WAIT_ACK  = 3'd4,
		CMD_SEND_ACK  = 3'd5,
		CMD_SEND_NACK = 3'd6,
		CMD_RSVD      = 3'd7
	} cmd_t;

	typedef struct packed {
		logic       start;
		cmd_t       cmd;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_in;
	} tick_item_t;

	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_level;
	} result_t;

	// Number of bus phases for each command.
	function automatic logic [PHASE_W-1:0] phase_count(cmd_t c);
		logic [PHASE_W-1:0] n;
		case (c)
			CMD_START:     n = PHASE_W'(3);
			CMD_STOP:      n = PHASE_W'(2);
			CMD_WRITE:     n = PHASE_W'(3 * BITS_PER_BYTE);
			CMD_READ:      n = PHASE_W'(2 * BITS_PER_BYTE + 3);
			CMD_WAIT_ACK,
			CMD_SEND_ACK,
			CMD_SEND_NACK: n = PHASE_W'(3);
			default:       n = '0;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/i2cbm_queue.sv
// Small register-based first-in first-out queue used between the engine parts.
module i2cbm_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rd_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/i2cbm_front.sv
// Front part: accepts tick items, classifies commands and queues them for the engine.
module i2cbm_front #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	output logic                   full,
	input  logic                   cmd_valid,
	input  logic [2:0]             cmd,
	input  logic [7:0]             tx_byte,
	input  logic                   send_ack,
	input  logic                   sda_in,
	output logic                   item_valid,
	input  logic                   item_take,
	output i2cbm_pkg::tick_item_t  item
);
	import i2cbm_pkg::*;

	tick_item_t in_item;
	logic       q_empty;
	cmd_t       cmd_code;

	// The reserved command code never starts a sequence.
	always_comb begin
		cmd_code         = cmd_t'(cmd);
		in_item.start    = cmd_valid && (cmd_code != CMD_RSVD);
		in_item.cmd      = cmd_code;
		in_item.tx_byte  = tx_byte;
		in_item.send_ack = send_ack;
		in_item.sda_in   = sda_in;
	end

	i2cbm_queue #(
		.WIDTH($bits(tick_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_data(in_item),
		.full   (full),
		.pop    (item_take),
		.empty  (q_empty),
		.rd_data(item)
	);

	assign item_valid = !q_empty;

endmodule

FILE: rtl/i2cbm_back.sv
// Back part: the bus phase sequencer and the result queue.
module i2cbm_back #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [i2cbm_pkg::TICK_W-1:0]  cfg_wr_data,
	input  logic                          item_valid,
	output logic                          item_take,
	input  i2cbm_pkg::tick_item_t         item,
	input  logic                          pop,
	output logic                          empty,
	output i2cbm_pkg::result_t            result
);
	import i2cbm_pkg::*;

	logic [TICK_W-1:0]    delay_q;
	logic [TICK_W-1:0]    tick_q, tick_n, tick_inc, delay_eff;
	logic [PHASE_W-1:0]   phase_q, phase_n, phase_inc;
	logic [1:0]           sub_q, sub_n, sub_inc;
	logic [BIT_IDX_W-1:0] bit_q, bit_n;
	logic [7:0]           shift_q, shift_n;
	cmd_t                 cmd_q, cmd_n;
	logic                 busy_q, busy_n;
	logic                 scl_q, scl_n;
	logic                 sda_q, sda_n;
	logic                 ack_q, ack_n;
	logic [7:0]           rx_q, rx_n;
	logic                 choice_q, choice_n;
	logic                 done_n;
	logic                 res_full;
	logic                 step;
	result_t              res_in;

	assign step      = item_valid && !res_full;
	assign item_take = step;
	assign delay_eff = (delay_q == '0) ? TICK_W'(1) : delay_q;
	assign tick_inc  = tick_q + TICK_W'(1);
	assign phase_inc = phase_q + PHASE_W'(1);
	assign sub_inc   = (sub_q == 2'd2) ? 2'd0 : sub_q + 2'd1;

	always_comb begin
		tick_n   = tick_q;
		phase_n  = phase_q;
		sub_n    = sub_q;
		bit_n    = bit_q;
		shift_n  = shift_q;
		cmd_n    = cmd_q;
		busy_n   = busy_q;
		scl_n    = scl_q;
		sda_n    = sda_q;
		ack_n    = ack_q;
		rx_n     = rx_q;
		choice_n = choice_q;
		done_n   = 1'b0;
		if (busy_q) begin
			tick_n = tick_inc;
			if (tick_inc >= delay_eff) begin
				tick_n  = '0;
				phase_n = phase_inc;
				sub_n   = sub_inc;
				// Actions at the end of the current phase.
				case (cmd_q)
					CMD_WRITE: begin
						if (sub_q == 2'd2) begin
							shift_n = {shift_q[6:0], 1'b0};
							bit_n   = bit_q + BIT_IDX_W'(1);
						end
					end
					CMD_READ: begin
						if (phase_q < READ_BIT_PHASES) begin
							if (!phase_q[0]) begin
								shift_n = {shift_q[6:0], item.sda_in};
							end else begin
								bit_n = bit_q + BIT_IDX_W'(1);
							end
						end
					end
					CMD_WAIT_ACK: begin
						if (phase_q == PHASE_W'(1)) begin
							ack_n = item.sda_in;
						end
					end
					default: begin
					end
				endcase
				if (phase_inc >= phase_count(cmd_q)) begin
					// Sequence complete.
					busy_n = 1'b0;
					done_n = 1'b1;
					case (cmd_q)
						CMD_STOP:     sda_n = 1'b1;
						CMD_READ: begin
							rx_n = shift_n;
							if (choice_q) begin
								sda_n = 1'b1;
							end
						end
						CMD_SEND_ACK: sda_n = 1'b1;
						default: begin
						end
					endcase
				end else begin
					// Levels applied on entry to the next phase.
					case (cmd_q)
						CMD_START: begin
							if (phase_inc == PHASE_W'(1)) begin
								sda_n = 1'b0;
							end else begin
								scl_n = 1'b0;
							end
						end
						CMD_STOP: scl_n = 1'b1;
						CMD_WRITE: begin
							case (sub_inc)
								2'd0: sda_n = shift_n[7];
								2'd1: scl_n = 1'b1;
								default: begin
									scl_n = 1'b0;
									if (bit_n == BIT_IDX_W'(BITS_PER_BYTE - 1)) begin
										sda_n = 1'b1;
									end
								end
							endcase
						end
						CMD_READ: begin
							if (phase_inc < READ_BIT_PHASES) begin
								scl_n = !phase_inc[0];
							end else if (phase_inc == READ_BIT_PHASES) begin
								sda_n = !choice_q;
							end else if (phase_inc == READ_BIT_PHASES + PHASE_W'(1)) begin
								scl_n = 1'b1;
							end else begin
								scl_n = 1'b0;
							end
						end
						default: begin
							if (phase_inc == PHASE_W'(1)) begin
								scl_n = 1'b1;
							end else begin
								scl_n = 1'b0;
							end
						end
					endcase
				end
			end
		end else if (item.start) begin
			cmd_n   = item.cmd;
			busy_n  = 1'b1;
			tick_n  = '0;
			phase_n = '0;
			sub_n   = 2'd0;
			bit_n   = '0;
			case (item.cmd)
				CMD_START: begin
					scl_n = 1'b1;
					sda_n = 1'b1;
				end
				CMD_STOP: begin
					scl_n = 1'b0;
					sda_n = 1'b0;
				end
				CMD_WRITE: begin
					shift_n = item.tx_byte;
					sda_n   = item.tx_byte[7];
				end
				CMD_READ: begin
					choice_n = item.send_ack;
					scl_n    = 1'b1;
				end
				default: sda_n = (item.cmd != CMD_SEND_ACK);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_RESET;
			tick_q   <= '0;
			phase_q  <= '0;
			sub_q    <= 2'd0;
			bit_q    <= '0;
			shift_q  <= '0;
			cmd_q    <= CMD_START;
			busy_q   <= 1'b0;
			scl_q    <= 1'b1;
			sda_q    <= 1'b1;
			ack_q    <= 1'b1;
			rx_q     <= '0;
			choice_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				delay_q <= cfg_wr_data;
			end
			if (step) begin
				tick_q   <= tick_n;
				phase_q  <= phase_n;
				sub_q    <= sub_n;
				bit_q    <= bit_n;
				shift_q  <= shift_n;
				cmd_q    <= cmd_n;
				busy_q   <= busy_n;
				scl_q    <= scl_n;
				sda_q    <= sda_n;
				ack_q    <= ack_n;
				rx_q     <= rx_n;
				choice_q <= choice_n;
			end
		end
	end

	always_comb begin
		res_in.scl_out   = scl_n;
		res_in.sda_out   = sda_n;
		res_in.busy_res  = busy_n;
		res_in.done_res  = done_n;
		res_in.rx_byte   = rx_n;
		res_in.ack_level = ack_n;
	end

	i2cbm_queue #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (step),
		.wr_data(res_in),
		.full   (res_full),
		.pop    (pop),
		.empty  (empty),
		.rd_data(result)
	);

endmodule

FILE: rtl/i2c_bit_level_master.sv
// Top level of the I2C master bit engine: tick queue, phase sequencer and result queue.
//
// Each item pushed is one tick of the bus timebase, carrying the sampled SDA level and
// optionally a command (start, stop, write byte, read byte with ACK or NACK, wait for ACK,
// send ACK, send NACK). Every item yields exactly one result item with the SCL and SDA
// drive levels (1 means released), busy, a one-tick done pulse, the last received byte and
// the last sampled ACK level. The engine takes one item per clock cycle while one waits
// and the result queue has room: a small command queue sits before the phase sequencer
// and a small result queue after it, so a stall on either side holds up the other only
// once the queues have run empty or full. An accepted item waits in the command queue
// until the sequencer takes it and queues its result. Each bus phase lasts delay_ticks
// items (0 acts as 1); commands arriving while a sequence runs, including on the tick that
// completes it, are ignored, as is the unused command code 7. The delay register resets
// to 200 and should only be written while all results have been popped.
module i2c_bit_level_master #(
	parameter int QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [i2cbm_pkg::TICK_W-1:0] cfg_wr_data,
	input  logic                         push,
	output logic                         full,
	input  logic                         cmd_valid,
	input  logic [2:0]                   cmd,
	input  logic [7:0]                   tx_byte,
	input  logic                         send_ack,
	input  logic                         sda_in,
	output logic                         empty,
	input  logic                         pop,
	output logic                         scl_out,
	output logic                         sda_out,
	output logic                         busy_res,
	output logic                         done_res,
	output logic [7:0]                   rx_byte,
	output logic                         ack_level
);
	import i2cbm_pkg::*;

	tick_item_t item;
	logic       item_valid;
	logic       item_take;
	result_t    result;

	// Front: decodes whether the tick starts a command and buffers it.
	i2cbm_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.tx_byte   (tx_byte),
		.send_ack  (send_ack),
		.sda_in    (sda_in),
		.item_valid(item_valid),
		.item_take (item_take),
		.item      (item)
	);

	// Back: advances the bus phases by one tick per item and queues the results.
	i2cbm_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.item_valid (item_valid),
		.item_take  (item_take),
		.item       (item),
		.pop        (pop),
		.empty      (empty),
		.result     (result)
	);

	assign scl_out   = result.scl_out;
	assign sda_out   = result.sda_out;
	assign busy_res  = result.busy_res;
	assign done_res  = result.done_res;
	assign rx_byte   = result.rx_byte;
	assign ack_level = result.ack_level;

endmodule

FILE: tb/sv/i2c_bit_level_master_test.sv
// Self-checking testbench of the I2C master bit engine with a tick-level bus predictor.
module i2c_bit_level_master_test;
	import i2cbm_pkg::*;

	// Idling schemes for the sender and the receiver of items.
	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// Choices for the sampled SDA level while a directed command runs.
	localparam int SDA_LOW = 0;
	localparam int SDA_HIGH = 1;
	localparam int SDA_RANDOM = 2;

	// The predictor runs the bus engine one tick per accepted item and keeps the
	// expected drive levels in arrival order. Results from the block are compared
	// with the oldest expectation.
	class i2c_level_scoreboard;
		logic [15:0] delay_ticks;
		logic [15:0] tick_cnt;
		logic [4:0]  step;
		logic [3:0]  bit_idx;
		logic [7:0]  shifter;
		cmd_t        running;
		logic        engine_busy;
		logic        scl;
		logic        sda;
		logic        ack_seen;
		logic        read_ack;
		logic [7:0]  rx_last;
		result_t     expected_levels[$];
		int unsigned mismatches;

		function new();
			delay_ticks = DELAY_RESET;
			tick_cnt = '0;
			step = '0;
			bit_idx = '0;
			shifter = '0;
			running = CMD_START;
			engine_busy = 1'b0;
			scl = 1'b1;
			sda = 1'b1;
			ack_seen = 1'b1;
			read_ack = 1'b0;
			rx_last = '0;
			mismatches = 0;
		endfunction

		function void set_delay(logic [15:0] value);
			delay_ticks = value;
		endfunction

		function logic [4:0] phases_for(cmd_t c);
			case (c)
				CMD_START: return 5'd3;
				CMD_STOP:  return 5'd2;
				CMD_WRITE: return 5'(3 * BITS_PER_BYTE);
				CMD_READ:  return 5'(2 * BITS_PER_BYTE + 3);
				CMD_RSVD:  return 5'd0;
				default:   return 5'd3;
			endcase
		endfunction

		// Drive levels set on entry to phase p.
		function void open_phase(logic [4:0] p);
			case (running)
				CMD_START: begin
					if (p == 0) begin
						scl = 1'b1;
						sda = 1'b1;
					end else if (p == 1) begin
						sda = 1'b0;
					end else begin
						scl = 1'b0;
					end
				end
				CMD_STOP: begin
					if (p == 0) begin
						sda = 1'b0;
						scl = 1'b0;
					end else begin
						scl = 1'b1;
					end
				end
				CMD_WRITE: begin
					case (p % 3)
						0: sda = shifter[7];
						1: scl = 1'b1;
						default: begin
							scl = 1'b0;
							if (bit_idx == BITS_PER_BYTE - 1) sda = 1'b1;
						end
					endcase
				end
				CMD_READ: begin
					if (p < 2 * BITS_PER_BYTE) scl = (p % 2 == 0);
					else if (p == 2 * BITS_PER_BYTE) sda = !read_ack;
					else if (p == 2 * BITS_PER_BYTE + 1) scl = 1'b1;
					else scl = 1'b0;
				end
				default: begin
					if (p == 0) sda = (running != CMD_SEND_ACK);
					else if (p == 1) scl = 1'b1;
					else scl = 1'b0;
				end
			endcase
		endfunction

		// Shifting and sampling done as phase p ends.
		function void close_phase(logic [4:0] p, logic line);
			if (running == CMD_WRITE) begin
				if (p % 3 == 2) begin
					shifter = shifter << 1;
					bit_idx = bit_idx + 1'b1;
				end
			end else if (running == CMD_READ) begin
				if (p < 2 * BITS_PER_BYTE) begin
					if (p % 2 == 0) shifter = {shifter[6:0], line};
					else bit_idx = bit_idx + 1'b1;
				end
			end else if (running == CMD_WAIT_ACK) begin
				if (p == 1) ack_seen = line;
			end
		endfunction

		function void finish_cmd();
			if (running == CMD_STOP) sda = 1'b1;
			if (running == CMD_READ) begin
				rx_last = shifter;
				if (read_ack) sda = 1'b1;
			end
			if (running == CMD_SEND_ACK) sda = 1'b1;
			engine_busy = 1'b0;
		endfunction

		// Notes one accepted item and queues the levels it must produce.
		function void note_tick(tick_item_t it);
			result_t     lv;
			logic        fin;
			logic [16:0] limit_ticks;
			fin = 1'b0;
			if (engine_busy) begin
				limit_ticks = (delay_ticks == 0) ? 17'd1 : {1'b0, delay_ticks};
				tick_cnt = tick_cnt + 1'b1;
				if ({1'b0, tick_cnt} >= limit_ticks) begin
					tick_cnt = '0;
					close_phase(step, it.sda_in);
					step = step + 1'b1;
					if (step >= phases_for(running)) begin
						finish_cmd();
						fin = 1'b1;
					end else begin
						open_phase(step);
					end
				end
			end else if (it.start && it.cmd != CMD_RSVD) begin
				running = it.cmd;
				engine_busy = 1'b1;
				tick_cnt = '0;
				step = '0;
				bit_idx = '0;
				if (it.cmd == CMD_WRITE) shifter = it.tx_byte;
				if (it.cmd == CMD_READ) read_ack = it.send_ack;
				open_phase(5'd0);
			end
			lv.scl_out = scl;
			lv.sda_out = sda;
			lv.busy_res = engine_busy;
			lv.done_res = fin;
			lv.rx_byte = rx_last;
			lv.ack_level = ack_seen;
			expected_levels.push_back(lv);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned seen);
			if (want != seen) begin
				$display("%0t: %s expected %0d actual %0d", $time, name, want, seen);
				mismatches++;
			end
		endfunction

		// Checks one result popped from the block against the oldest expectation.
		function void check_level(result_t got);
			result_t want;
			if (expected_levels.size() == 0) begin
				$display("%0t: result with nothing expected, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_levels.pop_front();
			compare_field("scl_out", want.scl_out, got.scl_out);
			compare_field("sda_out", want.sda_out, got.sda_out);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("rx_byte", want.rx_byte, got.rx_byte);
			compare_field("ack_level", want.ack_level, got.ack_level);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic        cmd_valid = 1'b0;
	logic [2:0]  cmd = '0;
	logic [7:0]  tx_byte = '0;
	logic        send_ack = 1'b0;
	logic        sda_in = 1'b1;
	logic        empty;
	logic        pop = 1'b0;
	logic        scl_out;
	logic        sda_out;
	logic        busy_res;
	logic        done_res;
	logic [7:0]  rx_byte;
	logic        ack_level;

	i2c_level_scoreboard board;
	idle_mode_t          mode = IDLE_NONE;

	// Commands of the bus transfer that the random part is working through.
	tick_item_t          transfer_script[$];

	i2c_bit_level_master dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.push       (push),
		.full       (full),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.tx_byte    (tx_byte),
		.send_ack   (send_ack),
		.sda_in     (sda_in),
		.empty      (empty),
		.pop        (pop),
		.scl_out    (scl_out),
		.sda_out    (sda_out),
		.busy_res   (busy_res),
		.done_res   (done_res),
		.rx_byte    (rx_byte),
		.ack_level  (ack_level)
	);

	always #5 clk = ~clk;

	function automatic tick_item_t make_tick(logic v, cmd_t c, logic [7:0] tx, logic sack,
			logic line);
		tick_item_t it;
		it.start = v;
		it.cmd = c;
		it.tx_byte = tx;
		it.send_ack = sack;
		it.sda_in = line;
		return it;
	endfunction

	// An item with no command; its command fields are random and must be ignored.
	function automatic tick_item_t idle_tick();
		return make_tick(1'b0, cmd_t'($urandom_range(7)), 8'($urandom_range(255)),
			1'($urandom_range(1)), 1'($urandom_range(1)));
	endfunction

	// Queues one well-formed transfer: start, address and ACK, a few data bytes, stop.
	function automatic void build_transfer();
		int n_bytes;
		int kind;
		n_bytes = $urandom_range(3, 1);
		transfer_script.push_back(make_tick(1'b1, CMD_START, '0, 1'b0, 1'b1));
		transfer_script.push_back(make_tick(1'b1, CMD_WRITE, 8'($urandom_range(255)), 1'b0,
			1'b1));
		transfer_script.push_back(make_tick(1'b1, CMD_WAIT_ACK, '0, 1'b0, 1'b1));
		for (int i = 0; i < n_bytes; i++) begin
			kind = $urandom_range(2);
			if (kind == 0) begin
				transfer_script.push_back(make_tick(1'b1, CMD_WRITE, 8'($urandom_range(255)),
					1'b0, 1'b1));
				transfer_script.push_back(make_tick(1'b1, CMD_WAIT_ACK, '0, 1'b0, 1'b1));
			end else if (kind == 1) begin
				transfer_script.push_back(make_tick(1'b1, CMD_READ, 8'($urandom_range(255)),
					1'($urandom_range(1)), 1'b1));
			end else begin
				// Read with no ACK of its own, acknowledged by a separate command.
				transfer_script.push_back(make_tick(1'b1, CMD_READ, 8'($urandom_range(255)),
					1'b0, 1'b1));
				transfer_script.push_back(make_tick(1'b1,
					$urandom_range(1) ? CMD_SEND_ACK : CMD_SEND_NACK, '0, 1'b0, 1'b1));
			end
		end
		transfer_script.push_back(make_tick(1'b1, CMD_STOP, '0, 1'b0, 1'b1));
	endfunction

	// Picks the next random item. While the engine runs, a few items carry commands
	// that must be ignored; while it is idle, most items start the next command of a
	// transfer, some are idle and some are stray commands that break the transfer.
	function automatic tick_item_t next_random_tick();
		tick_item_t it;
		tick_item_t step_item;
		it = idle_tick();
		if (board.engine_busy) begin
			it.start = ($urandom_range(99) < 10);
		end else if ($urandom_range(99) < 25) begin
			it.start = 1'b0;
		end else if ($urandom_range(99) < 12) begin
			it.start = 1'b1;
		end else begin
			if (transfer_script.size() == 0) build_transfer();
			step_item = transfer_script.pop_front();
			it.start = 1'b1;
			it.cmd = step_item.cmd;
			it.tx_byte = step_item.tx_byte;
			it.send_ack = step_item.send_ack;
		end
		return it;
	endfunction

	// Offers one item, with random gaps before it when the sender idles, and notes it
	// in the predictor at the edge where it is accepted.
	task automatic push_tick(tick_item_t it);
		int gap_pct;
		gap_pct = (mode == IDLE_SEND) ? 52 : (mode == IDLE_BOTH) ? 14 : 0;
		while ($urandom_range(99) < gap_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd_valid <= it.start;
		cmd <= it.cmd;
		tx_byte <= it.tx_byte;
		send_ack <= it.send_ack;
		sda_in <= it.sda_in;
		do @(posedge clk); while (full);
		board.note_tick(it);
	endtask

	// Stops offering items and waits until every expected result has been popped.
	task automatic drain_results();
		push <= 1'b0;
		do @(posedge clk); while (board.expected_levels.size() != 0);
	endtask

	// The delay register is written only once the block has handed out all results.
	// Idle cycles separate the last result from the write.
	task automatic write_delay(logic [15:0] value);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_delay(value);
	endtask

	// Runs one command to completion. The SDA level seen during the command is fixed
	// low, fixed high or random; with noisy set, every tick while the command runs
	// carries another command, which must be ignored, the completing tick among them.
	task automatic run_cmd(cmd_t c, logic [7:0] tx, logic sack, int sda_sel, bit noisy);
		while (board.engine_busy) push_tick(idle_tick());
		push_tick(make_tick(1'b1, c, tx, sack,
			(sda_sel == SDA_RANDOM) ? 1'($urandom_range(1)) : 1'(sda_sel)));
		while (board.engine_busy)
			push_tick(make_tick(noisy, cmd_t'($urandom_range(7)), 8'($urandom_range(255)),
				1'($urandom_range(1)),
				(sda_sel == SDA_RANDOM) ? 1'($urandom_range(1)) : 1'(sda_sel)));
	endtask

	// One random phase at a given delay and idling scheme. With hold set, the sender
	// halts halfway until every expected result has come back.
	task automatic run_random(int count, logic [15:0] delay, idle_mode_t m, bit hold);
		write_delay(delay);
		mode = m;
		transfer_script.delete();
		for (int i = 0; i < count; i++) begin
			if (hold && i == count / 2) drain_results();
			push_tick(next_random_tick());
		end
	endtask

	// The receiver pops at random according to the idling scheme and checks each
	// result item it takes. Outputs are read at the edge, before the block updates them.
	always @(posedge clk) begin : take_results
		result_t got;
		int      stall_pct;
		if (arst_n && pop && !empty) begin
			got.scl_out = scl_out;
			got.sda_out = sda_out;
			got.busy_res = busy_res;
			got.done_res = done_res;
			got.rx_byte = rx_byte;
			got.ack_level = ack_level;
			board.check_level(got);
		end
		stall_pct = (mode == IDLE_RECV) ? 52 : (mode == IDLE_BOTH) ? 14 : 0;
		pop <= ($urandom_range(99) >= stall_pct);
	end

	initial begin
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With the reset delay of 200 ticks, a start must cross one phase boundary.
		push_tick(make_tick(1'b1, CMD_START, '0, 1'b0, 1'b1));
		for (int i = 0; i < 220; i++) push_tick(idle_tick());

		// Raise the delay to its maximum mid-phase, then drop it to zero, which acts as
		// one tick: the phase under way ends on the very next tick.
		write_delay(16'hFFFF);
		for (int i = 0; i < 30; i++) push_tick(idle_tick());
		write_delay(16'h0000);

		// Directed commands: byte extremes, both ACK levels, both read endings, the
		// unused command code and commands thrown at a busy engine.
		run_cmd(CMD_START, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
		run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_RANDOM, 1'b1);
		run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_RANDOM, 1'b0);
		run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RANDOM, 1'b1);
		run_cmd(CMD_WAIT_ACK, 8'h00, 1'b0, SDA_LOW, 1'b0);
		run_cmd(CMD_WAIT_ACK, 8'hFF, 1'b1, SDA_HIGH, 1'b1);
		run_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 1'b0);
		run_cmd(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 1'b1);
		run_cmd(CMD_READ, 8'h5A, 1'b1, SDA_RANDOM, 1'b0);
		run_cmd(CMD_SEND_ACK, 8'h00, 1'b0, SDA_RANDOM, 1'b1);
		run_cmd(CMD_SEND_NACK, 8'h00, 1'b0, SDA_RANDOM, 1'b0);
		run_cmd(CMD_RSVD, 8'hFF, 1'b1, SDA_RANDOM, 1'b0);
		run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RANDOM, 1'b1);

		// Random transfers under each idling scheme, at short delays.
		run_random(260, 16'd1, IDLE_NONE, 1'b0);
		run_random(260, 16'd2, IDLE_SEND, 1'b1);
		run_random(260, 16'd3, IDLE_RECV, 1'b0);
		run_random(260, 16'd1, IDLE_BOTH, 1'b0);

		drain_results();
		// Extra idle cycles so that any result without an item behind it shows up.
		repeat (10) @(posedge clk);
		if (board.mismatches == 0 && board.expected_levels.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule

FILE: i2c_bit_level_master.f
rtl/i2cbm_pkg.sv
rtl/i2cbm_queue.sv
rtl/i2cbm_front.sv
rtl/i2cbm_back.sv
rtl/i2c_bit_level_master.sv
tb/sv/i2c_bit_level_master_test.sv
